// ===== hw/rtl/bit_sliced_bloom_signature_macros.svh =====
// assertion macros for the bloom signature block
`ifndef BIT_SLICED_BLOOM_SIGNATURE_MACROS_SVH
`define BIT_SLICED_BLOOM_SIGNATURE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BSB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BSB_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSB_ASSERT(label, clk, rst_n, prop, msg)
`define BSB_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/bsb_pkg.sv =====
// shared types, constants and hash helpers for the bloom signature block
package bsb_pkg;
    localparam int unsigned ROWS_DEFAULT = 4096;
    localparam int unsigned DOCS_DEFAULT = 64;
    localparam int unsigned MAX_HASHES_DEFAULT = 16;
    localparam int unsigned SIZE_W = 13;
    localparam int unsigned HCNT_W = 5;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4096);
    localparam logic [HCNT_W-1:0] HCNT_RESET = HCNT_W'(3);
    localparam logic [31:0] PR2 = 32'h85EBCA77;
    localparam logic [31:0] PR3 = 32'hC2B2AE3D;
    localparam logic [31:0] PR4 = 32'h27D4EB2F;
    localparam logic [31:0] PR5 = 32'h165667B1;
    localparam logic [31:0] KEY_BYTES = 32'd8;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_QUERY  = 1'b1
    } action_t;

    typedef struct packed {
        logic start;
        logic hash_step;
        logic mod_start;
        logic mem_rd;
        logic mem_wr;
        logic clear_wr;
    } bsb_cmd_t;

    typedef struct packed {
        logic hash_done;
        logic mod_done;
        logic bit_set;
    } bsb_stat_t;

    function automatic logic [31:0] rotl17(input logic [31:0] x);
        rotl17 = {x[14:0], x[31:15]};
    endfunction
endpackage

// ===== hw/rtl/bsb_hash.sv =====
// multicycle seeded xxh32 unit, one multiply per cycle
module bsb_hash
    import bsb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] key,
    input  logic [31:0] seed,
    output logic        done,
    output logic [31:0] hash
);
    logic [3:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] ma, mb;
    logic [63:0] prod;

    assign prod = 64'(ma) * 64'(mb);
    assign hash = h_reg;

    always_comb
    begin
        ma = 32'd0;
        mb = 32'd0;
        unique case (step_reg)
            4'd0: begin ma = key[31:0];  mb = PR3; end
            4'd1: begin ma = rotl17(h_reg); mb = PR4; end
            4'd2: begin ma = key[63:32]; mb = PR3; end
            4'd3: begin ma = rotl17(h_reg); mb = PR4; end
            4'd4: begin ma = h_reg;      mb = PR2; end
            4'd5: begin ma = h_reg;      mb = PR3; end
            default: begin ma = 32'd0;   mb = 32'd0; end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        h_next = h_reg;
        done = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 4'd0;
            h_next = seed + PR5 + KEY_BYTES;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 4'd1;
            unique case (step_reg)
                4'd0: h_next = h_reg + prod[31:0];
                4'd1: h_next = prod[31:0];
                4'd2: h_next = h_reg + prod[31:0];
                4'd3: h_next = prod[31:0] ^ (prod[31:0] >> 15);
                4'd4: h_next = prod[31:0] ^ (prod[31:0] >> 13);
                4'd5: h_next = prod[31:0] ^ (prod[31:0] >> 16);
                default:
                begin
                    busy_next = 1'b0;
                    done = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 4'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
    end
endmodule

// ===== hw/rtl/bsb_mod.sv =====
// restoring remainder unit, one quotient bit per cycle
module bsb_mod
    import bsb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [31:0]       dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic              done,
    output logic [SIZE_W-1:0] rem
);
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [31:0]       q_reg, q_next;
    logic [SIZE_W:0]   r_reg, r_next;
    logic [SIZE_W:0]   trial;

    assign trial = {r_reg[SIZE_W-1:0], q_reg[31]};
    assign rem = r_reg[SIZE_W-1:0];

    always_comb
    begin
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        q_next = q_reg;
        r_next = r_reg;
        done = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = 6'd0;
            q_next = dividend;
            r_next = '0;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[30:0], 1'b0};
            r_next = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
                busy_next = 1'b0;
        end
        else if (cnt_reg == 6'd32)
        begin
            done = 1'b1;
            cnt_next = 6'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 6'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end
endmodule

// ===== hw/rtl/bsb_datapath.sv =====
// datapath: key latch, hash and modulo units, signature memory
module bsb_datapath
    import bsb_pkg::*;
#(
    parameter int unsigned ROWS = ROWS_DEFAULT,
    parameter int unsigned DOCS = DOCS_DEFAULT,
    parameter int unsigned MAX_HASHES = MAX_HASHES_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  bsb_cmd_t          cmd,
    input  logic [63:0]       key,
    input  logic [5:0]        column,
    input  logic [SIZE_W-1:0] eff_size,
    input  logic [$clog2(MAX_HASHES+1)-1:0] seed,
    input  logic [$clog2(ROWS)-1:0] clear_row,
    output bsb_stat_t         stat
);
    localparam int unsigned AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned CW = (DOCS > 1) ? $clog2(DOCS) : 1;

    logic [DOCS-1:0]   mem [ROWS];
    logic [DOCS-1:0]   rd_reg;
    logic [63:0]       key_reg;
    logic [5:0]        col_reg;
    logic [31:0]       hash;
    logic [SIZE_W-1:0] rem;
    logic [AW-1:0]     row;
    logic [CW-1:0]     col_idx;
    logic              hash_done;
    logic              mod_done;

    assign row = AW'(rem);
    assign col_idx = CW'(col_reg);

    bsb_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.hash_step),
        .key   (key_reg),
        .seed  (32'(seed)),
        .done  (hash_done),
        .hash  (hash)
    );

    bsb_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .dividend (hash),
        .divisor  (eff_size),
        .done     (mod_done),
        .rem      (rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg <= key;
            col_reg <= column;
        end
        if (cmd.mem_rd)
            rd_reg <= mem[row];
        if (cmd.clear_wr)
            mem[clear_row[AW-1:0]] <= '0;
        else if (cmd.mem_wr)
            mem[row] <= rd_reg | (DOCS'(1) << col_idx);
    end

    assign stat = '{hash_done: hash_done, mod_done: mod_done, bit_set: rd_reg[col_idx]};
endmodule

// ===== hw/rtl/bsb_ctrl.sv =====
// controller: clearing pass, per-seed probe sequencing, result register
`include "bit_sliced_bloom_signature_macros.svh"
module bsb_ctrl
    import bsb_pkg::*;
#(
    parameter int unsigned ROWS = ROWS_DEFAULT,
    parameter int unsigned DOCS = DOCS_DEFAULT,
    parameter int unsigned MAX_HASHES = MAX_HASHES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_action,
    input  logic [5:0]  in_column,
    input  logic [HCNT_W-1:0] hash_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_kind,
    output logic        out_present,
    output bsb_cmd_t    cmd,
    output logic [$clog2(MAX_HASHES+1)-1:0] seed,
    output logic [$clog2(ROWS)-1:0] clear_row,
    input  bsb_stat_t   stat
);
    localparam int unsigned KW = $clog2(MAX_HASHES+1);
    localparam int unsigned RW = $clog2(ROWS);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_HASH, ST_MOD, ST_READ, ST_CHECK, ST_DONE
    } state_t;

    state_t        state_reg;
    logic [KW-1:0] k_reg;
    logic [KW-1:0] n_reg;
    logic [RW-1:0] clr_reg;
    logic          act_reg;
    logic          pres_reg;
    logic          ovalid_reg;
    logic          okind_reg;
    logic          opres_reg;
    logic [KW-1:0] n_eff;
    logic          col_ok;
    logic          accept;

    assign n_eff = (32'(hash_count) > MAX_HASHES) ? KW'(MAX_HASHES) : KW'(hash_count);
    assign col_ok = 32'(in_column) < DOCS;
    assign in_ready = (state_reg == ST_IDLE);
    assign accept = in_valid && in_ready;
    assign out_valid = ovalid_reg;
    assign out_kind = okind_reg;
    assign out_present = opres_reg;
    // seed of the hash being started: 0 on acceptance, next index after a check
    assign seed = (state_reg == ST_CHECK) ? k_reg + KW'(1) : '0;
    assign clear_row = clr_reg;

    always_comb
    begin
        cmd = '0;
        cmd.start = accept;
        cmd.hash_step = (state_reg == ST_IDLE && accept && col_ok && n_eff != '0)
                        || (state_reg == ST_CHECK && !(act_reg == ACT_QUERY && !stat.bit_set)
                            && k_reg + KW'(1) < n_reg);
        cmd.mod_start = (state_reg == ST_HASH) && stat.hash_done;
        cmd.mem_rd = (state_reg == ST_MOD) && stat.mod_done;
        cmd.mem_wr = (state_reg == ST_CHECK) && (act_reg == ACT_INSERT);
        cmd.clear_wr = (state_reg == ST_CLEAR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            k_reg <= '0;
            n_reg <= '0;
            clr_reg <= '0;
            act_reg <= 1'b0;
            pres_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            okind_reg <= 1'b0;
            opres_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && out_ready && state_reg != ST_DONE)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + RW'(1);
                    if (32'(clr_reg) == ROWS - 1)
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        act_reg <= in_action;
                        k_reg <= '0;
                        n_reg <= n_eff;
                        pres_reg <= col_ok;
                        if (col_ok && n_eff != '0)
                            state_reg <= ST_HASH;
                        else
                            state_reg <= ST_DONE;
                    end
                end
                ST_HASH:
                    if (stat.hash_done)
                        state_reg <= ST_MOD;
                ST_MOD:
                    if (stat.mod_done)
                        state_reg <= ST_READ;
                ST_READ:
                    state_reg <= ST_CHECK;
                ST_CHECK:
                begin
                    if (act_reg == ACT_QUERY && !stat.bit_set)
                    begin
                        pres_reg <= 1'b0;
                        state_reg <= ST_DONE;
                    end
                    else if (k_reg + KW'(1) < n_reg)
                    begin
                        k_reg <= k_reg + KW'(1);
                        state_reg <= ST_HASH;
                    end
                    else
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    // wait until the output register is free
                    if (!ovalid_reg || out_ready)
                    begin
                        ovalid_reg <= 1'b1;
                        okind_reg <= act_reg;
                        opres_reg <= (act_reg == ACT_QUERY) ? pres_reg : 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `BSB_ASSERT(a_no_accept_clear, clk, rst_n, (state_reg == ST_CLEAR) |-> !in_ready,
        "input accepted during clearing pass")
    `BSB_ASSERT(a_insert_absent, clk, rst_n, (out_valid && out_kind == ACT_INSERT) |-> !out_present,
        "insert reported present")
    `BSB_ASSERT(a_seed_range, clk, rst_n, (state_reg == ST_HASH) |-> (k_reg < n_reg),
        "seed beyond hash count")
endmodule

// ===== hw/rtl/bit_sliced_bloom_signature.sv =====
// top level of the bit-sliced bloom signature matrix
// per item, each hash index runs the hash unit, the remainder unit, a row read and a check
// a query stops at its first clear bit; zero hashes or a bad column go straight to the result
// one item in flight, the next accepted in the cycle after its result is loaded; remainder sets pace
// after reset a clearing pass zeroes every row of the matrix, inputs are held off
// reset: row count 4096, hash count 3
`include "bit_sliced_bloom_signature_macros.svh"
module bit_sliced_bloom_signature
    import bsb_pkg::*;
#(
    parameter int unsigned ROWS = ROWS_DEFAULT,
    parameter int unsigned DOCS = DOCS_DEFAULT,
    parameter int unsigned MAX_HASHES = MAX_HASHES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // kmer_value[63:0], doc_column[69:64], zeros
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // present, zeros
    output logic        m_axis_tuser    // kind
);
    localparam logic [2:0] ADDR_SIZE = 3'd0;
    localparam logic [2:0] ADDR_HCNT = 3'd4;

    logic [SIZE_W-1:0] size_reg;
    logic [HCNT_W-1:0] hcnt_reg;
    logic [SIZE_W-1:0] eff_size;
    logic              wr_en;
    bsb_cmd_t          cmd;
    bsb_stat_t         stat;
    logic [$clog2(MAX_HASHES+1)-1:0] seed;
    logic [$clog2(ROWS)-1:0] clear_row;
    logic              present;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign eff_size = (size_reg == '0) ? SIZE_W'(1)
                    : (32'(size_reg) > ROWS) ? SIZE_W'(ROWS) : size_reg;

    always_comb
    begin
        unique case (paddr)
            ADDR_SIZE: prdata = 32'(size_reg);
            ADDR_HCNT: prdata = 32'(hcnt_reg);
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
            hcnt_reg <= HCNT_RESET;
        end
        else if (wr_en)
        begin
            if (paddr == ADDR_SIZE)
                size_reg <= pwdata[SIZE_W-1:0];
            else if (paddr == ADDR_HCNT)
                hcnt_reg <= pwdata[HCNT_W-1:0];
        end
    end

    bsb_ctrl #(.ROWS(ROWS), .DOCS(DOCS), .MAX_HASHES(MAX_HASHES)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_action   (s_axis_tuser),
        .in_column   (s_axis_tdata[69:64]),
        .hash_count  (hcnt_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_kind    (m_axis_tuser),
        .out_present (present),
        .cmd         (cmd),
        .seed        (seed),
        .clear_row   (clear_row),
        .stat        (stat)
    );

    bsb_datapath #(.ROWS(ROWS), .DOCS(DOCS), .MAX_HASHES(MAX_HASHES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .key       (s_axis_tdata[63:0]),
        .column    (s_axis_tdata[69:64]),
        .eff_size  (eff_size),
        .seed      (seed),
        .clear_row (clear_row),
        .stat      (stat)
    );

    assign m_axis_tdata = {7'd0, present};
endmodule
